// ===== hdl/cbm_pkg.sv =====
// cbm_pkg: types and constants for the cartridge bank mapper with scanline IRQ.
// No dependencies; imported by cartridge_bank_mapper_scanline_irq_unit.
package cbm_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_CPU_MAP = 2'd2,
    ACT_PPU_MAP = 2'd3
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [15:0] address;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [20:0] mapped_address;
    logic        mapped_valid;
    logic        mirror_select;
    logic        irq_asserted;
  } result_t;

  // register decode, address AND DECODE_MASK
  localparam logic [15:0] DECODE_MASK  = 16'hF001;
  localparam logic [15:0] REG_COMMAND  = 16'h8000;
  localparam logic [15:0] REG_BANK     = 16'h8001;
  localparam logic [15:0] REG_MIRROR   = 16'hA000;
  localparam logic [15:0] REG_LATCH    = 16'hC000;
  localparam logic [15:0] REG_RELOAD   = 16'hC001;
  localparam logic [15:0] REG_IRQ_OFF  = 16'hE000;
  localparam logic [15:0] REG_IRQ_ON   = 16'hE001;

  localparam int unsigned CMD_CHR_1K_BIT = 5;   // command bit: 1 KB CHR slots
  localparam logic [7:0]  BANK_RESET     = 8'hFF;
  localparam logic [7:0]  PRG_FIXED_BANK = 8'hFF;
  localparam logic [15:0] PPU_WINDOW_TOP = 16'h1FFF;

endpackage

// ===== hdl/cartridge_bank_mapper_scanline_irq_unit.sv =====
// Results are registered: each accepted transaction's result is captured in the result register and shown at out_o.
// Throughput: one transaction per cycle; decode, bank select and counter update are one
//   level of logic ahead of the result register, and in_stall_o only follows output stall.
// Reset (rst_ni low, async): command/mirror/IRQ state cleared, all sixteen bank
//   registers set to 0xFF, result register empty.
// Depends on cbm_pkg.
module cartridge_bank_mapper_scanline_irq_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cbm_pkg::item_t  in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cbm_pkg::result_t out_o
);
  import cbm_pkg::*;

  // mapper state
  logic [7:0] cmd_q, cmd_d;
  logic       mirror_q, mirror_d;
  logic [7:0] bank_lo_q [8];
  logic [7:0] bank_hi_q [8];
  logic [8:0] cnt_q, cnt_d;          // signed scanline counter
  logic [7:0] latch_q, latch_d;
  logic       irq_en_q, irq_en_d;
  logic       reload_q, reload_d;
  logic       irq_q, irq_d;

  // result register
  logic    out_valid_q;
  result_t out_q, out_d;

  logic        in_fire;
  logic [15:0] dec_addr;
  logic        bank_we;
  logic [2:0]  lo_idx, hi_idx;
  logic [7:0]  lo_bank, hi_bank;
  logic [2:0]  chr_slot;
  logic [7:0]  chr_bank;
  logic [7:0]  prg_bank;
  logic [20:0] map_addr;
  logic        map_hit;

  // The result stage frees up when it is empty or its transaction leaves this cycle.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign dec_addr   = in_i.address & DECODE_MASK;

  // ---------------------------------------------------------------------------
  // State update for writes and ticks
  // ---------------------------------------------------------------------------
  always_comb begin
    cmd_d    = cmd_q;
    mirror_d = mirror_q;
    cnt_d    = cnt_q;
    latch_d  = latch_q;
    irq_en_d = irq_en_q;
    reload_d = reload_q;
    irq_d    = irq_q;
    bank_we  = 1'b0;
    if (in_fire && in_i.action == ACT_WRITE) begin
      case (dec_addr)
        REG_COMMAND: cmd_d = in_i.data;
        REG_BANK:    bank_we = 1'b1;
        REG_MIRROR:  mirror_d = in_i.data[0];
        REG_LATCH: begin
          latch_d = in_i.data;
          // reload uses the new latch value
          if (reload_q) cnt_d = {1'b0, in_i.data};
        end
        REG_RELOAD: begin
          reload_d = 1'b1;
          cnt_d    = {1'b0, latch_q};
        end
        REG_IRQ_OFF: begin
          irq_en_d = 1'b0;
          irq_d    = 1'b0;   // acknowledge
          if (reload_q) cnt_d = {1'b0, latch_q};
        end
        REG_IRQ_ON: begin
          irq_en_d = 1'b1;
          if (reload_q) cnt_d = {1'b0, latch_q};
        end
        default: ;
      endcase
    end else if (in_fire && in_i.action == ACT_TICK) begin
      reload_d = 1'b0;
      if (!cnt_q[8]) begin
        cnt_d = cnt_q - 9'd1;
        // counter passes zero into -1
        if (cnt_q == 9'd0 && irq_en_q) begin
          reload_d = 1'b1;
          irq_d    = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Address translation: one read of each bank register file
  // ---------------------------------------------------------------------------
  assign chr_slot = in_i.address[12:10];

  always_comb begin
    if (in_i.action == ACT_CPU_MAP) begin
      lo_idx = in_i.address[13] ? 3'd7 : 3'd6;
      hi_idx = 3'd7;
    end else begin
      lo_idx = chr_slot[2] ? (chr_slot - 3'd2) : {2'b00, chr_slot[1]};
      hi_idx = {2'b00, chr_slot[1]};
    end
  end

  assign lo_bank = bank_lo_q[lo_idx];
  assign hi_bank = bank_hi_q[hi_idx];

  // odd slots of the lower 4 KB use the high file only in 1 KB mode
  assign chr_bank = (!chr_slot[2] && chr_slot[0]) ? hi_bank : lo_bank;

  always_comb begin
    case (in_i.address[14:13])
      2'd0, 2'd1: prg_bank = lo_bank;
      2'd2:       prg_bank = hi_bank;
      default:    prg_bank = PRG_FIXED_BANK;
    endcase
  end

  always_comb begin
    map_addr = '0;
    map_hit  = 1'b0;
    case (in_i.action)
      ACT_CPU_MAP: begin
        if (in_i.address[15]) begin
          map_hit  = 1'b1;
          map_addr = {prg_bank, in_i.address[12:0]};
        end
      end
      ACT_PPU_MAP: begin
        if (in_i.address <= PPU_WINDOW_TOP) begin
          map_hit = 1'b1;
          if (chr_slot[2] || cmd_q[CMD_CHR_1K_BIT]) begin
            map_addr = {3'b000, chr_bank, in_i.address[9:0]};
          end else begin
            map_addr = {3'b000, lo_bank[7:1], in_i.address[10:0]};
          end
        end
      end
      default: ;
    endcase
  end

  // mirror select (the inverted mirror bit) and IRQ level report the state after the transaction
  always_comb begin
    out_d.mapped_address = map_addr;
    out_d.mapped_valid   = map_hit;
    out_d.mirror_select  = ~mirror_d;
    out_d.irq_asserted   = irq_d;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= '0;
      mirror_q <= 1'b0;
      cnt_q    <= '0;
      latch_q  <= '0;
      irq_en_q <= 1'b0;
      reload_q <= 1'b0;
      irq_q    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        bank_lo_q[i] <= BANK_RESET;
        bank_hi_q[i] <= BANK_RESET;
      end
    end else begin
      cmd_q    <= cmd_d;
      mirror_q <= mirror_d;
      cnt_q    <= cnt_d;
      latch_q  <= latch_d;
      irq_en_q <= irq_en_d;
      reload_q <= reload_d;
      irq_q    <= irq_d;
      if (bank_we) begin
        if (cmd_q[3]) bank_hi_q[cmd_q[2:0]] <= in_i.data;
        else          bank_lo_q[cmd_q[2:0]] <= in_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // the IRQ line only rises on a scanline tick
  a_irq_rise_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(irq_q) |-> $past(in_fire && in_i.action == ACT_TICK))
    else $error("IRQ rose without a tick");

  // a tick on a negative counter leaves it at -1
  a_cnt_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.action == ACT_TICK && cnt_q[8]) |=> (cnt_q == 9'h1FF))
    else $error("negative counter moved on tick");

  // writes and ticks never report a mapped address
  a_nonmap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_i.action[1]) |=> (!out_q.mapped_valid && out_q.mapped_address == '0))
    else $error("non-translate transaction produced a mapping");

  // CPU translate in the upper half always hits
  a_prg_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.action == ACT_CPU_MAP && in_i.address[15]) |=> out_q.mapped_valid)
    else $error("PRG window miss");

endmodule
